// ----- design/lzss_pkg.sv -----
// Shared constants for the LZSS stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

    // Byte and window geometry
    localparam int BYTE_W       = 8;
    localparam int WINDOW_DEPTH = 4096;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    // Token format
    localparam int DIST_W    = 12;
    localparam int LEN_W     = 5;
    localparam int LEN_BIAS  = 3;
    localparam int FLAG_BITS = 8;
    localparam int FLAGS_W   = 4;

endpackage

`default_nettype wire

// ----- design/lzss_if.sv -----
// Stream channel interfaces for compressed input and decompressed output.
`timescale 1ns / 1ps
`default_nettype none

interface lzss_in_if;
    import lzss_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if;
    import lzss_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              from_match;

    modport source (output valid, output out_byte, output run_last, output from_match,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input from_match,
                    output ready);
endinterface

`default_nettype wire

// ----- design/lzss_ram.sv -----
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps
`default_nettype none

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/lzss_stream_decoder_core.sv -----
// Top level of the LZSS stream decoder: token parser, copy engine, window RAM.
//
//  channel       | dir | payload                          | word accepted when
//  --------------+-----+----------------------------------+-------------------
//  compressed    | in  | in_byte[7:0], in_last            | valid && ready
//  decompressed  | out | out_byte[7:0], run_last, from_m. | valid && ready
//
// A pair-high word starts a copy of 3..18 bytes through the window RAM read
// loop: one copied byte leaves per cycle once the first read has returned and
// while the output register can be loaded.
// After reset a clearing pass zeroes all WINDOW_DEPTH (4096) window entries,
// during which no word is accepted. Input is held off while the output
// register is full and not being taken; a stalled copy simply pauses.
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decoder_core (
    input  logic clk,
    input  logic rst_n,
    lzss_in_if.sink    compressed,
    lzss_out_if.source decompressed
);
    import lzss_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IN    = 3'b010,
        ST_COPY  = 3'b100
    } lzss_state_t;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(WINDOW_DEPTH - 1);

    // Window index plus one, wrapping at the window depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_ADDR) ? '0 : p + PTR_W'(1);
    endfunction

    // Control state
    lzss_state_t         state_reg, state_next;
    logic [PTR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [BYTE_W-1:0]   flag_shift_reg, flag_shift_next;
    logic [FLAGS_W-1:0]  flags_left_reg, flags_left_next;
    logic [1:0]          phase_reg, phase_next;
    logic [BYTE_W-1:0]   pair_low_reg, pair_low_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]    reads_left_reg, reads_left_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                coll_reg, coll_next;
    logic                last_pend_reg, last_pend_next;
    logic                out_valid_reg, out_valid_next;

    // Payload
    logic [BYTE_W-1:0]   fwd_reg, fwd_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                run_last_reg, run_last_next;
    logic                from_match_reg, from_match_next;

    // RAM port signals
    logic                ram_we, ram_re;
    logic [PTR_W-1:0]    ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [BYTE_W-1:0]   ram_rdata;

    logic                can_load, acc, consume, issue, load;
    logic [BYTE_W-1:0]   copy_byte;
    logic [DIST_W-1:0]   back_dist;
    logic [PTR_W:0]      rd_diff;
    logic [PTR_W-1:0]    rd_start;

    lzss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Handshake
    assign can_load  = !out_valid_reg || decompressed.ready;
    assign compressed.ready = (state_reg == ST_IN) && can_load;
    assign acc       = compressed.valid && compressed.ready;
    assign consume   = (state_reg == ST_COPY) && rd_pend_reg && can_load;
    assign issue     = (state_reg == ST_COPY) && (reads_left_reg != '0)
                       && (!rd_pend_reg || consume);
    assign copy_byte = coll_reg ? fwd_reg : ram_rdata;

    // Copy source start: write pointer minus distance, modulo the depth
    assign back_dist = {compressed.in_byte[7:4], pair_low_reg};
    assign rd_diff   = {1'b0, wp_reg} - (PTR_W+1)'(back_dist);
    assign rd_start  = rd_diff[PTR_W] ? PTR_W'(rd_diff + (PTR_W+1)'(WINDOW_DEPTH))
                                      : rd_diff[PTR_W-1:0];

    assign ram_re = issue;

    // Parser, copy engine and window write
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        wp_next         = wp_reg;
        flag_shift_next = flag_shift_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        pair_low_next   = pair_low_reg;
        rd_ptr_next     = rd_ptr_reg;
        bytes_left_next = bytes_left_reg;
        reads_left_next = reads_left_reg;
        rd_pend_next    = rd_pend_reg;
        coll_next       = coll_reg;
        last_pend_next  = last_pend_reg;
        fwd_next        = fwd_reg;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        from_match_next = from_match_reg;
        load            = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = compressed.in_byte;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = ptr_inc(clr_cnt_reg);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IN;
                end
            end

            ST_IN:
            begin
                if (acc)
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (flag_shift_reg[0])
                            begin
                                // literal
                                load            = 1'b1;
                                ram_we          = 1'b1;
                                out_byte_next   = compressed.in_byte;
                                run_last_next   = 1'b1;
                                from_match_next = 1'b0;
                                wp_next         = ptr_inc(wp_reg);
                                flag_shift_next = flag_shift_reg >> 1;
                                flags_left_next = flags_left_reg - FLAGS_W'(1);
                                phase_next      = (flags_left_reg == FLAGS_W'(1))
                                                  ? PH_FLAG : PH_TOKEN;
                            end
                            else
                            begin
                                pair_low_next = compressed.in_byte;
                                phase_next    = PH_HIGH;
                            end
                        end

                        PH_HIGH:
                        begin
                            // start a copy; token bookkeeping done now
                            state_next      = ST_COPY;
                            rd_ptr_next     = rd_start;
                            bytes_left_next = LEN_W'(compressed.in_byte[3:0])
                                              + LEN_W'(LEN_BIAS);
                            reads_left_next = LEN_W'(compressed.in_byte[3:0])
                                              + LEN_W'(LEN_BIAS);
                            last_pend_next  = compressed.in_last;
                            flag_shift_next = flag_shift_reg >> 1;
                            flags_left_next = flags_left_reg - FLAGS_W'(1);
                            phase_next      = (flags_left_reg == FLAGS_W'(1))
                                              ? PH_FLAG : PH_TOKEN;
                        end

                        default:
                        begin
                            // flag word, also for the unused phase code
                            flag_shift_next = compressed.in_byte;
                            flags_left_next = FLAGS_W'(FLAG_BITS);
                            phase_next      = PH_TOKEN;
                        end
                    endcase

                    // stream end: back to a flag word, pointer rewinds (at copy end for a pair-high word)
                    if (compressed.in_last)
                    begin
                        phase_next      = PH_FLAG;
                        flags_left_next = '0;
                        flag_shift_next = '0;
                        pair_low_next   = '0;
                        if (phase_reg != PH_HIGH)
                        begin
                            wp_next = '0;
                        end
                    end
                end
            end

            ST_COPY:
            begin
                if (issue)
                begin
                    rd_ptr_next     = ptr_inc(rd_ptr_reg);
                    reads_left_next = reads_left_reg - LEN_W'(1);
                    // read meets the write of this cycle: forward the byte
                    coll_next       = consume && (rd_ptr_reg == wp_reg);
                    fwd_next        = copy_byte;
                end
                rd_pend_next = issue || (rd_pend_reg && !consume);
                if (consume)
                begin
                    load            = 1'b1;
                    ram_we          = 1'b1;
                    ram_wdata       = copy_byte;
                    out_byte_next   = copy_byte;
                    run_last_next   = (bytes_left_reg == LEN_W'(1));
                    from_match_next = 1'b1;
                    bytes_left_next = bytes_left_reg - LEN_W'(1);
                    wp_next         = ptr_inc(wp_reg);
                    if (bytes_left_reg == LEN_W'(1))
                    begin
                        state_next = ST_IN;
                        if (last_pend_reg)
                        begin
                            wp_next = '0;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !decompressed.ready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            wp_reg         <= '0;
            flag_shift_reg <= '0;
            flags_left_reg <= '0;
            phase_reg      <= PH_FLAG;
            pair_low_reg   <= '0;
            rd_ptr_reg     <= '0;
            bytes_left_reg <= '0;
            reads_left_reg <= '0;
            rd_pend_reg    <= 1'b0;
            coll_reg       <= 1'b0;
            last_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            wp_reg         <= wp_next;
            flag_shift_reg <= flag_shift_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            pair_low_reg   <= pair_low_next;
            rd_ptr_reg     <= rd_ptr_next;
            bytes_left_reg <= bytes_left_next;
            reads_left_reg <= reads_left_next;
            rd_pend_reg    <= rd_pend_next;
            coll_reg       <= coll_next;
            last_pend_reg  <= last_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fwd_reg        <= fwd_next;
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        from_match_reg <= from_match_next;
    end

    assign decompressed.valid      = out_valid_reg;
    assign decompressed.out_byte   = out_byte_reg;
    assign decompressed.run_last   = run_last_reg;
    assign decompressed.from_match = from_match_reg;

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || decompressed.ready))
        else $error("output word overwritten before it was taken");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |->
            (bytes_left_reg == reads_left_reg + LEN_W'(rd_pend_reg)))
        else $error("copy read and byte counters out of step");

    a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && bytes_left_reg == LEN_W'(1)) |=>
            (decompressed.valid && decompressed.run_last && state_reg == ST_IN))
        else $error("final copied byte not marked or copy not finished");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_cnt_reg == LAST_ADDR) |=>
            (state_reg == ST_IN && !decompressed.valid))
        else $error("clearing pass did not hand over cleanly");

endmodule

`default_nettype wire

// ----- tb/tb_lzss_stream_decoder_core.sv -----
// Testbench for the LZSS stream decoder: directed and random compressed streams, checked per byte.
`timescale 1ns / 1ps
`default_nettype none

module tb_lzss_stream_decoder_core;
    import lzss_pkg::*;

    // Parser phases of the predictor
    typedef enum logic [1:0] {
        EXPECT_FLAG      = 2'd0,
        EXPECT_TOKEN     = 2'd1,
        EXPECT_PAIR_HIGH = 2'd2
    } parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              from_match;
    } out_word_t;

    logic clk;
    logic rst_n;

    lzss_in_if  comp_ch ();
    lzss_out_if decomp_ch ();

    lzss_stream_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .compressed   (comp_ch),
        .decompressed (decomp_ch)
    );

    // Predictor state
    logic [BYTE_W-1:0] decoded_window [WINDOW_DEPTH];
    logic [PTR_W-1:0]  write_ptr;
    logic [BYTE_W-1:0] flag_bits;
    logic [FLAGS_W-1:0] tokens_left;
    parse_phase_t      parse_phase;
    logic [BYTE_W-1:0] pair_low;

    out_word_t expected_bytes [$];
    out_word_t burst_q [$];
    logic [BYTE_W-1:0] stream_q [$];

    int fail_count;
    int words_sent;
    int bytes_checked;
    int copied_bytes;
    int streams_sent;
    bit tx_idle;
    bit rx_idle;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic clear_decoder_model();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            decoded_window[i] = '0;
        write_ptr   = '0;
        flag_bits   = '0;
        tokens_left = '0;
        parse_phase = EXPECT_FLAG;
        pair_low    = '0;
    endtask

    function automatic void store_byte(logic [BYTE_W-1:0] b, logic m);
        out_word_t w;
        w.data       = b;
        w.run_last   = 1'b0;
        w.from_match = m;
        burst_q.push_back(w);
        decoded_window[write_ptr] = b;
        write_ptr = write_ptr + 1'b1;
    endfunction

    function automatic void finish_token();
        flag_bits = flag_bits >> 1;
        if (tokens_left > 0)
            tokens_left = tokens_left - 1'b1;
        parse_phase = (tokens_left == 0) ? EXPECT_FLAG : EXPECT_TOKEN;
    endfunction

    // Expected decompressed bytes for one accepted compressed word
    function automatic void decode_word(logic [BYTE_W-1:0] b, logic last);
        logic [PTR_W-1:0] back_dist;
        logic [PTR_W-1:0] src;
        int               len;
        out_word_t        w;
        burst_q.delete();
        case (parse_phase)
            EXPECT_TOKEN:
            begin
                if (flag_bits[0])
                begin
                    store_byte(b, 1'b0);
                    finish_token();
                end
                else
                begin
                    pair_low    = b;
                    parse_phase = EXPECT_PAIR_HIGH;
                end
            end
            EXPECT_PAIR_HIGH:
            begin
                back_dist = {b[7:4], pair_low};
                len  = int'(b[3:0]) + LEN_BIAS;
                for (int i = 0; i < len; i++)
                begin
                    src = write_ptr - back_dist;
                    store_byte(decoded_window[src], 1'b1);
                end
                finish_token();
            end
            default:
            begin
                flag_bits   = b;
                tokens_left = FLAGS_W'(FLAG_BITS);
                parse_phase = EXPECT_TOKEN;
            end
        endcase
        for (int i = 0; i < burst_q.size(); i++)
        begin
            w = burst_q[i];
            if (i == burst_q.size() - 1)
                w.run_last = 1'b1;
            expected_bytes.push_back(w);
        end
        // End of stream: back to a flag byte, pointer rewinds, window kept
        if (last)
        begin
            parse_phase = EXPECT_FLAG;
            tokens_left = '0;
            flag_bits   = '0;
            pair_low    = '0;
            write_ptr   = '0;
        end
    endfunction

    // Predict on input words, check output words against the oldest expectation
    always @(posedge clk)
    begin : scoreboard
        out_word_t exp_w;
        if (rst_n)
        begin
            if (comp_ch.valid && comp_ch.ready)
                decode_word(comp_ch.in_byte, comp_ch.in_last);
            if (decomp_ch.valid && decomp_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output word: out_byte %0h run_last %0b from_match %0b",
                           decomp_ch.out_byte, decomp_ch.run_last, decomp_ch.from_match);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_bytes.pop_front();
                    bytes_checked++;
                    if (exp_w.from_match)
                        copied_bytes++;
                    if (decomp_ch.out_byte !== exp_w.data)
                    begin
                        $error("out_byte: expected %0h, actual %0h",
                               exp_w.data, decomp_ch.out_byte);
                        fail_count++;
                    end
                    if (decomp_ch.run_last !== exp_w.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b",
                               exp_w.run_last, decomp_ch.run_last);
                        fail_count++;
                    end
                    if (decomp_ch.from_match !== exp_w.from_match)
                    begin
                        $error("from_match: expected %0b, actual %0b",
                               exp_w.from_match, decomp_ch.from_match);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Output side: random stall before each word while rx_idle is set
    initial
    begin : output_sink
        int stall;
        decomp_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                decomp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            decomp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(decomp_ch.valid && decomp_ch.ready));
            @(negedge clk);
        end
    end

    // Send one compressed word; entered and left at a falling edge
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            comp_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        comp_ch.in_byte <= b;
        comp_ch.in_last <= last;
        comp_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!(comp_ch.valid && comp_ch.ready));
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_word(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    // Well-formed groups with random content; optionally cut at any word
    task automatic build_stream(input int groups, input bit cut);
        logic [BYTE_W-1:0] f;
        int                tokens;
        int                keep;
        stream_q.delete();
        for (int g = 0; g < groups; g++)
        begin
            f = BYTE_W'($urandom);
            tokens = (g == groups - 1) ? $urandom_range(1, FLAG_BITS) : FLAG_BITS;
            stream_q.push_back(f);
            for (int t = 0; t < tokens; t++)
            begin
                if (f[t])
                    stream_q.push_back(BYTE_W'($urandom));
                else if ($urandom_range(0, 1))
                begin
                    // near distance, mostly inside what this stream has written
                    stream_q.push_back(BYTE_W'($urandom_range(1, 20)));
                    stream_q.push_back({4'h0, 4'($urandom)});
                end
                else
                begin
                    stream_q.push_back(BYTE_W'($urandom));
                    stream_q.push_back(BYTE_W'($urandom));
                end
            end
        end
        if (cut)
        begin
            keep = $urandom_range(1, stream_q.size());
            while (stream_q.size() > keep)
                void'(stream_q.pop_back());
        end
    endtask

    task automatic test_literal_run();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        streams_sent++;
    endtask

    task automatic test_match_cases();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_word(8'h0F, 1'b0);
        send_word(8'h11, 1'b0);
        send_word(8'h22, 1'b0);
        send_word(8'h33, 1'b0);
        send_word(8'h44, 1'b0);
        // distance one, shortest copy
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        // overlapping copy, longest length
        send_word(8'h04, 1'b0);
        send_word(8'h0F, 1'b0);
        // zero distance reads the entry about to be overwritten
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        // largest distance reaches before the stream start
        send_word(8'hFF, 1'b0);
        send_word(8'hF2, 1'b1);
        streams_sent++;
    endtask

    task automatic test_stream_ends();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        // pair cut short after its low byte
        send_word(8'h00, 1'b0);
        send_word(8'h07, 1'b1);
        // stream of a flag byte alone
        send_word(8'h01, 1'b1);
        // stream ending on a literal
        send_word(8'h01, 1'b0);
        send_word(8'hC3, 1'b1);
        streams_sent += 3;
    endtask

    task automatic test_random_streams();
        int kind;
        while (words_sent < 220)
        begin
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise
                stream_q.delete();
                repeat ($urandom_range(1, 12)) stream_q.push_back(BYTE_W'($urandom));
            end
            else
                build_stream($urandom_range(1, 3), kind <= 2);
            send_stream();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        comp_ch.valid   = 1'b0;
        comp_ch.in_byte = '0;
        comp_ch.in_last = 1'b0;
        fail_count      = 0;
        words_sent      = 0;
        bytes_checked   = 0;
        copied_bytes    = 0;
        streams_sent    = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        clear_decoder_model();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_literal_run();
        test_match_cases();
        test_stream_ends();
        test_random_streams();

        comp_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Covered %0d compressed words in %0d streams, %0d output bytes checked",
                 words_sent, streams_sent, bytes_checked);
        $display("(%0d copied from the window), with random stalls on both sides",
                 copied_bytes);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- lzss_stream_decoder_core.f -----
design/lzss_pkg.sv
design/lzss_if.sv
design/lzss_ram.sv
design/lzss_stream_decoder_core.sv
tb/tb_lzss_stream_decoder_core.sv
